FILE: hdl/lir_pkg.sv
// lir_pkg: shared types and fixed constants for the linear interpolation resampler
// used by lir_front, lir_back and linear_interp_resampler_pcm16; depends on nothing

package lir_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W   = 2;
  localparam int STEP_W  = 25;
  localparam int LIMIT_W = 24;
  localparam int PCM_W   = 16;
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 1;

  localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [INDEX_W-1:0] REG_STEP  = 1'b0;
  localparam logic [INDEX_W-1:0] REG_LIMIT = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 25'd65536;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd65535;

  // output full scale is 2^15 - 1, so the gain is a shift and a subtract
  localparam int               GAIN_SHIFT = 15;
  localparam logic [PCM_W-1:0] PCM_MAX    = 16'd32767;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TAKE,
    OP_RESTART
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CFG  = 2'd1,
    STAT_TOO_MANY = 2'd2,
    STAT_REJECTED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MUL,
    S_SUM,
    S_SCALE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

endpackage

FILE: hdl/lir_front.sv
// lir_front: takes input items, decodes the command and holds them in a short queue
// depends on lir_pkg

module lir_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lir_pkg::CMD_W-1:0]           command,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  input  logic                                pop,
  output lir_pkg::head_t                      head,
  output logic signed [SAMPLE_BITS-1:0]       head_sample
);

  lir_pkg::op_t                 q_op     [lir_pkg::QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] q_sample [lir_pkg::QUEUE_DEPTH];

  logic [lir_pkg::QPTR_W-1:0] wr_ptr;
  logic [lir_pkg::QPTR_W-1:0] rd_ptr;
  logic [lir_pkg::QCNT_W-1:0] count;

  logic         accept;
  logic         push;
  lir_pkg::op_t push_op;

  assign in_stall = (count == lir_pkg::QCNT_W'(lir_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  // unused command code is dropped here and never reaches the back end
  always_comb begin
    push    = 1'b0;
    push_op = lir_pkg::OP_SAMPLE;
    case (command)
      lir_pkg::CMD_SAMPLE: begin
        push    = accept;
        push_op = lir_pkg::OP_SAMPLE;
      end
      lir_pkg::CMD_TAKE: begin
        push    = accept;
        push_op = lir_pkg::OP_TAKE;
      end
      lir_pkg::CMD_RESTART: begin
        push    = accept;
        push_op = lir_pkg::OP_RESTART;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]     <= push_op;
      q_sample[wr_ptr] <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lir_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lir_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + lir_pkg::QCNT_W'(1);
        2'b01:   count <= count - lir_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign head.valid  = (count != '0);
  assign head.op     = q_op[rd_ptr];
  assign head_sample = q_sample[rd_ptr];

endmodule

FILE: hdl/lir_back.sv
// lir_back: stream state, interpolation datapath and output register of the resampler
// depends on lir_pkg; fed by lir_front

module lir_back #(
  parameter int SAMPLE_BITS            = 24,
  parameter int PHASE_FRAC_BITS        = 16,
  parameter int MAX_OUTPUTS_PER_SAMPLE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lir_pkg::head_t                      head,
  input  logic signed [SAMPLE_BITS-1:0]       head_sample,
  output logic                                pop,
  input  logic [lir_pkg::STEP_W-1:0]          step_q16,
  input  logic [lir_pkg::LIMIT_W-1:0]         max_buffered_samples,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lir_pkg::PCM_W-1:0]    pcm_out,
  output logic [lir_pkg::STAT_W-1:0]          status,
  output logic                                last
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PF     = PHASE_FRAC_BITS;
  localparam int POS_W  = (PF >= lir_pkg::STEP_W) ? PF + 2 : lir_pkg::STEP_W + 1;
  localparam int ITER_W = $clog2(MAX_OUTPUTS_PER_SAMPLE + 1);
  localparam int PROD_W = SB + PF + 2;
  localparam int V_W    = PROD_W + 1;
  localparam int K      = SB - 1 + PF;
  localparam int MAG_W  = K + 1;
  localparam int SC_W   = MAG_W + lir_pkg::GAIN_SHIFT;

  localparam logic [POS_W-1:0]          POS_ONE  = POS_W'(1) << PF;
  localparam logic [PF:0]               W_ONE    = POS_ONE[PF:0];
  localparam int                        MIN_STEP_I =
    ((1 << PF) + MAX_OUTPUTS_PER_SAMPLE - 1) / MAX_OUTPUTS_PER_SAMPLE;
  localparam logic [lir_pkg::STEP_W-1:0] MIN_STEP = lir_pkg::STEP_W'(MIN_STEP_I);
  localparam logic [ITER_W-1:0]         ITER_MAX = ITER_W'(MAX_OUTPUTS_PER_SAMPLE);
  localparam logic [SC_W-1:0]           HALF     = SC_W'(1) << (K - 1);

  lir_pkg::state_t  state, state_next;
  logic [POS_W-1:0] rel_position, rel_position_next;
  logic signed [SB-1:0] prev_sample, prev_sample_next;
  logic             have_prev, have_prev_next;
  lir_pkg::status_t error_code, error_code_next;
  logic [lir_pkg::LIMIT_W-1:0] buffered_count, buffered_count_next;

  logic [POS_W-1:0]     pos, pos_next;
  logic [ITER_W-1:0]    iter, iter_next;
  logic signed [SB-1:0] cur_sample, cur_sample_next;
  logic [PF:0]          wpos, wpos_next;
  logic signed [PROD_W-1:0] prod_a, prod_a_next;
  logic signed [PROD_W-1:0] prod_b, prod_b_next;
  logic [MAG_W-1:0]     mag, mag_next;
  logic                 neg, neg_next;
  logic [lir_pkg::PCM_W-1:0] res_pcm, res_pcm_next;
  lir_pkg::status_t     res_status, res_status_next;
  logic                 res_last, res_last_next;
  logic                 ret_walk, ret_walk_next;

  logic                 out_valid_next;
  logic signed [lir_pkg::PCM_W-1:0] pcm_out_next;
  logic [lir_pkg::STAT_W-1:0] status_next;
  logic                 last_next;

  logic                 cfg_bad;
  logic [POS_W-1:0]     pos_step;
  logic [ITER_W-1:0]    iter_inc;
  logic                 in_loop;
  logic [PF:0]          weight_a;
  logic signed [PF+1:0] weight_a_s;
  logic signed [PF+1:0] weight_b_s;
  logic signed [V_W-1:0] sum_v;
  logic signed [V_W-1:0] abs_v;
  logic [SC_W-1:0]      scaled;
  logic [lir_pkg::PCM_W-1:0] rounded;
  logic [lir_pkg::PCM_W-1:0] clamped;

  assign cfg_bad = (step_q16 == '0) || (step_q16 < MIN_STEP) || (max_buffered_samples == '0);

  assign pos_step = pos + POS_W'(step_q16);
  assign iter_inc = iter + ITER_W'(1);
  assign in_loop  = (pos <= POS_ONE) && (iter < ITER_MAX);

  assign weight_a   = W_ONE - wpos;
  assign weight_a_s = $signed({1'b0, weight_a});
  assign weight_b_s = $signed({1'b0, wpos});

  assign sum_v = V_W'(prod_a) + V_W'(prod_b);
  assign abs_v = sum_v[V_W-1] ? -sum_v : sum_v;

  // mag * 32767 plus half an lsb, then drop the fraction
  assign scaled  = (SC_W'(mag) << lir_pkg::GAIN_SHIFT) - SC_W'(mag) + HALF;
  assign rounded = scaled[SC_W-1:K];
  assign clamped = (rounded > lir_pkg::PCM_MAX) ? lir_pkg::PCM_MAX : rounded;

  always_comb begin
    state_next          = state;
    rel_position_next   = rel_position;
    prev_sample_next    = prev_sample;
    have_prev_next      = have_prev;
    error_code_next     = error_code;
    buffered_count_next = buffered_count;
    pos_next            = pos;
    iter_next           = iter;
    cur_sample_next     = cur_sample;
    wpos_next           = wpos;
    prod_a_next         = prod_a;
    prod_b_next         = prod_b;
    mag_next            = mag;
    neg_next            = neg;
    res_pcm_next        = res_pcm;
    res_status_next     = res_status;
    res_last_next       = res_last;
    ret_walk_next       = ret_walk;
    out_valid_next      = out_valid;
    pcm_out_next        = pcm_out;
    status_next         = status;
    last_next           = last;
    pop                 = 1'b0;

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      lir_pkg::S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.op)
            lir_pkg::OP_TAKE: begin
              buffered_count_next = '0;
            end
            lir_pkg::OP_RESTART: begin
              buffered_count_next = '0;
              rel_position_next   = POS_ONE;
              prev_sample_next    = '0;
              have_prev_next      = 1'b0;
              error_code_next     = lir_pkg::STAT_OK;
            end
            lir_pkg::OP_SAMPLE: begin
              if (error_code != lir_pkg::STAT_OK) begin
                res_pcm_next    = '0;
                res_status_next = lir_pkg::STAT_REJECTED;
                res_last_next   = 1'b1;
                ret_walk_next   = 1'b0;
                state_next      = lir_pkg::S_EMIT;
              end else if (cfg_bad) begin
                error_code_next = lir_pkg::STAT_BAD_CFG;
                res_pcm_next    = '0;
                res_status_next = lir_pkg::STAT_BAD_CFG;
                res_last_next   = 1'b1;
                ret_walk_next   = 1'b0;
                state_next      = lir_pkg::S_EMIT;
              end else begin
                cur_sample_next = head_sample;
                pos_next        = rel_position;
                iter_next       = '0;
                state_next      = lir_pkg::S_WALK;
              end
            end
            default: begin
              state_next = lir_pkg::S_IDLE;
            end
          endcase
        end
      end

      lir_pkg::S_WALK: begin
        if (in_loop) begin
          iter_next = iter_inc;
          if (!have_prev && (pos < POS_ONE)) begin
            // no previous sample yet: positions before the new one give nothing
            pos_next = pos_step;
          end else if (buffered_count >= max_buffered_samples) begin
            error_code_next = lir_pkg::STAT_TOO_MANY;
            res_pcm_next    = '0;
            res_status_next = lir_pkg::STAT_TOO_MANY;
            res_last_next   = 1'b1;
            ret_walk_next   = 1'b0;
            state_next      = lir_pkg::S_EMIT;
          end else begin
            wpos_next           = pos[PF:0];
            // every later pass of the loop yields a result, so look one step ahead
            res_last_next       = !((pos_step <= POS_ONE) && (iter_inc < ITER_MAX));
            buffered_count_next = buffered_count + lir_pkg::LIMIT_W'(1);
            pos_next            = pos_step;
            state_next          = lir_pkg::S_MUL;
          end
        end else begin
          rel_position_next = (pos > POS_ONE) ? pos - POS_ONE : '0;
          prev_sample_next  = cur_sample;
          have_prev_next    = 1'b1;
          state_next        = lir_pkg::S_IDLE;
        end
      end

      lir_pkg::S_MUL: begin
        prod_a_next = PROD_W'(prev_sample) * PROD_W'(weight_a_s);
        prod_b_next = PROD_W'(cur_sample) * PROD_W'(weight_b_s);
        state_next  = lir_pkg::S_SUM;
      end

      lir_pkg::S_SUM: begin
        neg_next   = sum_v[V_W-1];
        mag_next   = abs_v[MAG_W-1:0];
        state_next = lir_pkg::S_SCALE;
      end

      lir_pkg::S_SCALE: begin
        res_pcm_next    = neg ? -clamped : clamped;
        res_status_next = lir_pkg::STAT_OK;
        ret_walk_next   = 1'b1;
        state_next      = lir_pkg::S_EMIT;
      end

      lir_pkg::S_EMIT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          pcm_out_next   = res_pcm;
          status_next    = res_status;
          last_next      = res_last;
          state_next     = ret_walk ? lir_pkg::S_WALK : lir_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lir_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lir_pkg::S_IDLE;
      rel_position   <= POS_ONE;
      prev_sample    <= '0;
      have_prev      <= 1'b0;
      error_code     <= lir_pkg::STAT_OK;
      buffered_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      rel_position   <= rel_position_next;
      prev_sample    <= prev_sample_next;
      have_prev      <= have_prev_next;
      error_code     <= error_code_next;
      buffered_count <= buffered_count_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    iter       <= iter_next;
    cur_sample <= cur_sample_next;
    wpos       <= wpos_next;
    prod_a     <= prod_a_next;
    prod_b     <= prod_b_next;
    mag        <= mag_next;
    neg        <= neg_next;
    res_pcm    <= res_pcm_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    ret_walk   <= ret_walk_next;
    pcm_out    <= pcm_out_next;
    status     <= status_next;
    last       <= last_next;
  end

endmodule

FILE: hdl/linear_interp_resampler_pcm16.sv
// linear_interp_resampler_pcm16: top level, configuration registers and the two halves
// depends on lir_pkg, lir_front and lir_back
//
// Mono linear-interpolation sample-rate converter producing PCM16. Items are queued
// two deep in front of the processing engine, so input is taken while results wait.
// A take or restart command is handled in the idle state. A sample starts in idle,
// walks past each read position skipped before the first sample, passes each output
// through position step, two multipliers, sum, gain and rounding, and the output
// register (held there by any output stall), and ends with a closing walk step; error
// results skip straight to the output register. Outputs share one multiply/scale path.
// step_q16 and max_buffered_samples may be written at any time the block is idle.

module linear_interp_resampler_pcm16 #(
  parameter int SAMPLE_BITS            = 24,
  parameter int PHASE_FRAC_BITS        = 16,
  parameter int MAX_OUTPUTS_PER_SAMPLE = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lir_pkg::CMD_W-1:0]           command,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lir_pkg::PCM_W-1:0]    pcm_out,
  output logic [lir_pkg::STAT_W-1:0]          status,
  output logic                                last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lir_pkg::INDEX_W-1:0]         cfg_index,
  input  logic [lir_pkg::STEP_W-1:0]          cfg_data
);

  logic [lir_pkg::STEP_W-1:0]  step_q16;
  logic [lir_pkg::LIMIT_W-1:0] max_buffered_samples;

  lir_pkg::head_t              head;
  logic signed [SAMPLE_BITS-1:0] head_sample;
  logic                        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q16             <= lir_pkg::STEP_RESET;
      max_buffered_samples <= lir_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lir_pkg::REG_STEP:  step_q16 <= cfg_data;
        lir_pkg::REG_LIMIT: max_buffered_samples <= cfg_data[lir_pkg::LIMIT_W-1:0];
        default: begin
          step_q16 <= step_q16;
        end
      endcase
    end
  end

  lir_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .sample_in   (sample_in),
    .pop         (pop),
    .head        (head),
    .head_sample (head_sample)
  );

  lir_back #(
    .SAMPLE_BITS            (SAMPLE_BITS),
    .PHASE_FRAC_BITS        (PHASE_FRAC_BITS),
    .MAX_OUTPUTS_PER_SAMPLE (MAX_OUTPUTS_PER_SAMPLE)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .head                 (head),
    .head_sample          (head_sample),
    .pop                  (pop),
    .step_q16             (step_q16),
    .max_buffered_samples (max_buffered_samples),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .pcm_out              (pcm_out),
    .status               (status),
    .last                 (last)
  );

endmodule

FILE: test/tb_linear_interp_resampler_pcm16.sv
// tb_linear_interp_resampler_pcm16: self-checking bench for the pcm16 resampler top level
// predicts each output item from the accepted input items and compares it field by field
// depends on lir_pkg and linear_interp_resampler_pcm16

module tb_linear_interp_resampler_pcm16;

  localparam int     SAMPLE_BITS   = 24;
  localparam int     FRAC_BITS     = 16;
  localparam int     MAX_OUTPUTS   = 64;
  localparam longint POS_ONE       = 64'd1 << FRAC_BITS;
  localparam longint MIN_STEP      = (POS_ONE + MAX_OUTPUTS - 1) / MAX_OUTPUTS;
  localparam int     SCALE_SHIFT   = SAMPLE_BITS - 1 + FRAC_BITS;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     LONG_HOLD     = 400;

  localparam logic [lir_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = 24'sh800000;

  typedef struct packed {
    logic signed [lir_pkg::PCM_W-1:0] pcm;
    lir_pkg::status_t                 stat;
    logic                             last;
  } pcm_result_t;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [lir_pkg::CMD_W-1:0]         command;
  logic signed [SAMPLE_BITS-1:0]     sample_in;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [lir_pkg::PCM_W-1:0]  pcm_out;
  logic [lir_pkg::STAT_W-1:0]        status;
  logic                              last;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [lir_pkg::INDEX_W-1:0]       cfg_index;
  logic [lir_pkg::STEP_W-1:0]        cfg_data;

  // predictor state and the outputs still owed by the block
  longint           step_cfg;
  longint           limit_cfg;
  longint           read_pos;
  longint           prev_smp;
  logic             have_prev;
  lir_pkg::status_t fault;
  longint           held_count;
  pcm_result_t      pending_pcm[$];

  int   mismatches = 0;
  logic gaps_on    = 1'b1;
  logic rx_hold    = 1'b0;
  int   rx_wait    = 0;

  linear_interp_resampler_pcm16 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pcm_out   (pcm_out),
    .status    (status),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic push_result(input logic signed [lir_pkg::PCM_W-1:0] pcm,
                             input lir_pkg::status_t stat, input logic fin);
    pcm_result_t res;
    res.pcm  = pcm;
    res.stat = stat;
    res.last = fin;
    pending_pcm.push_back(res);
  endtask

  // works out the outputs of one accepted item and updates the predictor state
  task automatic resample_item(input logic [lir_pkg::CMD_W-1:0] cmd,
                               input logic signed [SAMPLE_BITS-1:0] smp);
    longint                           pos;
    longint                           cur;
    longint                           acc;
    logic [63:0]                      mag;
    logic [63:0]                      rounded;
    logic signed [lir_pkg::PCM_W-1:0] pcm;
    int                               iter;
    int                               produced;
    logic                             full;
    pcm_result_t                      res;
    cur      = longint'(smp);
    iter     = 0;
    produced = 0;
    full     = 1'b0;
    case (cmd)
      lir_pkg::CMD_TAKE: held_count = 0;
      lir_pkg::CMD_RESTART: begin
        held_count = 0;
        read_pos   = POS_ONE;
        prev_smp   = 0;
        have_prev  = 1'b0;
        fault      = lir_pkg::STAT_OK;
      end
      lir_pkg::CMD_SAMPLE: begin
        if (fault != lir_pkg::STAT_OK) begin
          push_result('0, lir_pkg::STAT_REJECTED, 1'b1);
        end else if (step_cfg == 0 || step_cfg < MIN_STEP || limit_cfg == 0) begin
          fault = lir_pkg::STAT_BAD_CFG;
          push_result('0, lir_pkg::STAT_BAD_CFG, 1'b1);
        end else begin
          pos = read_pos;
          while (pos <= POS_ONE && iter < MAX_OUTPUTS && !full) begin
            iter++;
            if (!have_prev && pos < POS_ONE) begin
              pos += step_cfg;
            end else if (held_count >= limit_cfg) begin
              fault = lir_pkg::STAT_TOO_MANY;
              push_result('0, lir_pkg::STAT_TOO_MANY, 1'b1);
              full = 1'b1;
            end else begin
              acc = prev_smp * (POS_ONE - pos) + cur * pos;
              mag = (acc < 0) ? -acc : acc;
              // gain of 32767 and rounding half away from zero on the magnitude
              rounded = (mag * 64'd32767 + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
              if (rounded > 64'd32767) rounded = 64'd32767;
              pcm = (acc < 0) ? -rounded[lir_pkg::PCM_W-1:0] : rounded[lir_pkg::PCM_W-1:0];
              push_result(pcm, lir_pkg::STAT_OK, 1'b0);
              produced++;
              held_count++;
              pos += step_cfg;
            end
          end
          // an overflow leaves position and history untouched
          if (!full) begin
            read_pos  = (pos > POS_ONE) ? pos - POS_ONE : 0;
            prev_smp  = cur;
            have_prev = 1'b1;
            if (produced > 0) begin
              res      = pending_pcm.pop_back();
              res.last = 1'b1;
              pending_pcm.push_back(res);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [lir_pkg::CMD_W-1:0] cmd,
                           input logic signed [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    sample_in <= smp;
    do @(posedge clk); while (in_stall);
    resample_item(cmd, smp);
  endtask

  // idle means nothing owed and time for queued silent items to finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lir_pkg::INDEX_W-1:0] idx,
                           input logic [lir_pkg::STEP_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lir_pkg::REG_STEP) begin
      step_cfg = longint'(data);
    end else begin
      limit_cfg = longint'(data[lir_pkg::LIMIT_W-1:0]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker, also draws the receiver pause after each item
  always @(posedge clk) begin : check_results
    pcm_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pcm.size() == 0) begin
        report_mismatch($sformatf("unexpected item pcm %0d status %0d", pcm_out, status));
      end else begin
        want = pending_pcm.pop_front();
        if (pcm_out !== want.pcm)
          report_mismatch($sformatf("pcm_out %0d, predicted %0d", pcm_out, want.pcm));
        if (status !== want.stat)
          report_mismatch($sformatf("status %0d, predicted %0d", status, want.stat));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, predicted %0b", last, want.last));
      end
      rx_wait = gaps_on ? int'($urandom_range(0, 4)) : 0;
    end
  end

  always @(negedge clk) begin
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_unity_step();
    send_item(lir_pkg::CMD_SAMPLE, SMP_MAX);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MIN);
    send_item(lir_pkg::CMD_SAMPLE, '0);
    send_item(lir_pkg::CMD_SAMPLE, 24'sd1);
    send_item(lir_pkg::CMD_SAMPLE, -24'sd1);
  endtask

  task automatic test_commands();
    send_item(lir_pkg::CMD_TAKE, SMP_MAX);
    send_item(CMD_UNUSED, SMP_MIN);
    send_item(lir_pkg::CMD_RESTART, '0);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MIN);
  endtask

  // smallest legal step gives the full burst of outputs per item
  task automatic test_min_step();
    write_reg(lir_pkg::REG_STEP, lir_pkg::STEP_W'(MIN_STEP));
    send_item(lir_pkg::CMD_SAMPLE, SMP_MAX);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MIN);
  endtask

  task automatic test_bad_config();
    write_reg(lir_pkg::REG_STEP, lir_pkg::STEP_W'(MIN_STEP - 1));
    send_item(lir_pkg::CMD_SAMPLE, 24'sh123456);
    send_item(lir_pkg::CMD_SAMPLE, 24'sh123456);
    send_item(lir_pkg::CMD_TAKE, '0);
    send_item(lir_pkg::CMD_SAMPLE, '0);
    send_item(lir_pkg::CMD_RESTART, '0);
    write_reg(lir_pkg::REG_STEP, '0);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MAX);
    send_item(lir_pkg::CMD_RESTART, '0);
    write_reg(lir_pkg::REG_STEP, lir_pkg::STEP_W'(POS_ONE));
    write_reg(lir_pkg::REG_LIMIT, '0);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MIN);
    send_item(lir_pkg::CMD_RESTART, '0);
  endtask

  // limit runs out part way through the outputs of the second item
  task automatic test_limit();
    write_reg(lir_pkg::REG_STEP, lir_pkg::STEP_W'(POS_ONE / 4));
    write_reg(lir_pkg::REG_LIMIT, 25'd3);
    send_item(lir_pkg::CMD_SAMPLE, 24'sh200000);
    send_item(lir_pkg::CMD_SAMPLE, -24'sh200000);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MAX);
    send_item(lir_pkg::CMD_RESTART, '0);
  endtask

  task automatic test_wide_step();
    write_reg(lir_pkg::REG_STEP, '1);
    write_reg(lir_pkg::REG_LIMIT, '1);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MAX);
    send_item(lir_pkg::CMD_SAMPLE, SMP_MIN);
    send_item(lir_pkg::CMD_RESTART, '0);
  endtask

  // receiver holds off while the sender keeps going, so the input queue fills
  task automatic test_backpressure();
    logic [31:0] rnd;
    write_reg(lir_pkg::REG_STEP, lir_pkg::STEP_W'(POS_ONE / 4));
    gaps_on = 1'b0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (24) begin
      rnd = $urandom;
      send_item(lir_pkg::CMD_SAMPLE, rnd[SAMPLE_BITS-1:0]);
    end
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    logic [31:0]                   rnd;
    logic [lir_pkg::STEP_W-1:0]    step;
    logic [lir_pkg::STEP_W-1:0]    limit;
    logic [lir_pkg::CMD_W-1:0]     cmd;
    logic signed [SAMPLE_BITS-1:0] smp;
    int                            roll;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 9))
        0:       step = lir_pkg::STEP_W'(MIN_STEP);
        1:       step = lir_pkg::STEP_W'($urandom_range(0, MIN_STEP - 1));
        2:       step = lir_pkg::STEP_W'(POS_ONE);
        3:       step = lir_pkg::STEP_W'($urandom_range(POS_ONE + 1, 25'h1FFFFFF));
        default: step = lir_pkg::STEP_W'($urandom_range(MIN_STEP, 4 * POS_ONE));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        limit = lir_pkg::STEP_W'($urandom_range(1, 300));
      end else begin
        limit = lir_pkg::STEP_W'($urandom_range(300, 24'hFFFFFF));
      end
      write_reg(lir_pkg::REG_STEP, step);
      write_reg(lir_pkg::REG_LIMIT, limit);
      gaps_on = ($urandom_range(0, 3) != 0);
      send_item(lir_pkg::CMD_RESTART, '0);
      repeat (36) begin
        roll = int'($urandom_range(0, 99));
        // mostly clear a held error soon so the stream keeps producing output
        if (fault != lir_pkg::STAT_OK && roll < 40) cmd = lir_pkg::CMD_RESTART;
        else if (roll < 84)                         cmd = lir_pkg::CMD_SAMPLE;
        else if (roll < 92)                         cmd = lir_pkg::CMD_TAKE;
        else if (roll < 96)                         cmd = lir_pkg::CMD_RESTART;
        else                                        cmd = CMD_UNUSED;
        rnd = $urandom;
        case ($urandom_range(0, 19))
          0:       smp = SMP_MAX;
          1:       smp = SMP_MIN;
          default: smp = rnd[SAMPLE_BITS-1:0];
        endcase
        send_item(cmd, smp);
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = lir_pkg::CMD_SAMPLE;
    sample_in  = '0;
    cfg_valid  = 1'b0;
    cfg_index  = lir_pkg::REG_STEP;
    cfg_data   = '0;
    step_cfg   = longint'(lir_pkg::STEP_RESET);
    limit_cfg  = longint'(lir_pkg::LIMIT_RESET);
    read_pos   = POS_ONE;
    prev_smp   = 0;
    have_prev  = 1'b0;
    fault      = lir_pkg::STAT_OK;
    held_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_unity_step();
    test_commands();
    test_min_step();
    test_bad_config();
    test_limit();
    test_wide_step();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
